// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. They compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/u8d_pkg.sv =====
`timescale 1ns / 1ps

package u8d_pkg;

   // Width of a code point, of a text byte and of the packed result data.
   localparam int unsigned CP_W        = 21;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RSP_TDATA_W = 24;

   // What the decode step hands to the output register for one item.
   typedef struct packed {
      logic            emit;
      logic [CP_W-1:0] code_point;
      logic            last;
   } step_type;

endpackage

// ===== hw/rtl/u8d_core.sv =====
`timescale 1ns / 1ps

module u8d_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [u8d_pkg::BYTE_W-1:0] text_byte,
   input  logic                      end_of_text,
   output u8d_pkg::step_type         step
);

   logic [1:0]               remaining_ff;
   logic [1:0]               remaining_in;
   logic [u8d_pkg::CP_W-1:0] partial_ff;
   logic [u8d_pkg::CP_W-1:0] partial_in;

   logic [u8d_pkg::CP_W-1:0] lead_value;
   logic [1:0]               lead_more;
   logic [u8d_pkg::CP_W-1:0] acc_value;
   logic [1:0]               remaining_dec;

   // Lead byte decode: the prefix picks the length and the payload bits.
   always_comb begin
      unique casez (text_byte)
         8'b0???????: begin
            lead_value = u8d_pkg::CP_W'(text_byte);
            lead_more  = 2'd0;
         end
         8'b110?????: begin
            lead_value = u8d_pkg::CP_W'(text_byte[4:0]);
            lead_more  = 2'd1;
         end
         8'b1110????: begin
            lead_value = u8d_pkg::CP_W'(text_byte[3:0]);
            lead_more  = 2'd2;
         end
         8'b11110???: begin
            lead_value = u8d_pkg::CP_W'(text_byte[2:0]);
            lead_more  = 2'd3;
         end
         default: begin
            // An invalid lead passes through as a one-byte character.
            lead_value = u8d_pkg::CP_W'(text_byte);
            lead_more  = 2'd0;
         end
      endcase
   end

   // Any byte inside a sequence adds its low six bits, whatever its top bits are.
   assign acc_value     = {partial_ff[u8d_pkg::CP_W-7:0], text_byte[5:0]};
   assign remaining_dec = remaining_ff - 2'd1;

   // Result of this item and the state it leaves behind.
   always_comb begin
      step.last = end_of_text;
      if (remaining_ff == 2'd0) begin
         step.emit       = (lead_more == 2'd0) || end_of_text;
         step.code_point = lead_value;
      end else begin
         step.emit       = (remaining_dec == 2'd0) || end_of_text;
         step.code_point = acc_value;
      end
      if (step.emit) begin
         remaining_in = 2'd0;
         partial_in   = '0;
      end else if (remaining_ff == 2'd0) begin
         remaining_in = lead_more;
         partial_in   = lead_value;
      end else begin
         remaining_in = remaining_dec;
         partial_in   = acc_value;
      end
   end

   // Sequence state moves only when an item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
         partial_ff   <= '0;
      end else if (advance) begin
         remaining_ff <= remaining_in;
         partial_ff   <= partial_in;
      end
   end

endmodule

// ===== hw/rtl/utf8_codepoint_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)         tuser  tlast
// req_      in         text_byte[7:0]             -      end_of_text
// rsp_      out        code_point[20:0], 3 zeros  -      last_of_text
//
// One input byte per cycle while no result waits on a stalled rsp_; a result passes the input register,
// the single decode step and the output register. The rate is set by that decode step.
// Reset clears the valid flags and the sequence state; no sequence is open afterwards.
// A stalled rsp_ holds its item; bytes that make no result keep flowing meanwhile.

`include "assert_macros.svh"

module utf8_codepoint_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [u8d_pkg::BYTE_W-1:0]       req_tdata,   // text_byte[7:0]
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [u8d_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // code_point[20:0], zero fill
   output logic                             rsp_tlast
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_eot_ff;

   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [u8d_pkg::CP_W-1:0]    out_cp_ff;
   logic                        out_last_ff;

   logic                        out_free;
   logic                        advance;
   u8d_pkg::step_type           step;

   // Handshake: an item moves on unless it makes a result and the output slot is full.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && (!step.emit || out_free);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = (advance && step.emit) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   // Decode step with the open-sequence state.
   u8d_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .step        (step)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.emit) begin
         out_cp_ff   <= step.code_point;
         out_last_ff <= step.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(u8d_pkg::RSP_TDATA_W - u8d_pkg::CP_W){1'b0}}, out_cp_ff};
   assign rsp_tlast  = out_last_ff;

   // The final byte of a text always closes whatever sequence is open.
   `ASSERT_PROP(a_eot_emits, clock, reset, (advance && in_eot_ff) |-> step.emit)
   // A result never overwrites one that is still waiting.
   `ASSERT_NEVER(a_no_overwrite, clock, reset, advance && step.emit && !out_free)
   // A waiting result holds still until it is taken.
   `ASSERT_PROP(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))

endmodule

// ===== test/utf8_codepoint_decoder_test.sv =====
`timescale 1ns / 1ps

// One decoded code point as the block should present it.
typedef struct packed {
   logic [u8d_pkg::CP_W-1:0] code_point;
   logic                     last;
} code_point_item_type;

// Tracks the decoder state and holds the code points still owed by the block.
class code_point_tracker;
   logic [1:0]                cont_left;
   logic [u8d_pkg::CP_W-1:0]  cp_accum;
   code_point_item_type       owed_code_points[$];
   int unsigned               fail_count;

   function new();
      cont_left  = 2'd0;
      cp_accum   = '0;
      fail_count = 0;
   endfunction

   // Advances the decoder state by one accepted byte and queues any code point it completes.
   function void note_byte(logic [u8d_pkg::BYTE_W-1:0] text_byte, logic end_of_text);
      logic [u8d_pkg::CP_W-1:0] lead_value;
      logic [1:0]               lead_more;
      code_point_item_type      item;
      if (cont_left == 2'd0) begin
         // A lead byte picks the sequence length; anything unknown passes through.
         casez (text_byte)
            8'b0???????: begin
               lead_value = u8d_pkg::CP_W'(text_byte);
               lead_more  = 2'd0;
            end
            8'b110?????: begin
               lead_value = u8d_pkg::CP_W'(text_byte[4:0]);
               lead_more  = 2'd1;
            end
            8'b1110????: begin
               lead_value = u8d_pkg::CP_W'(text_byte[3:0]);
               lead_more  = 2'd2;
            end
            8'b11110???: begin
               lead_value = u8d_pkg::CP_W'(text_byte[2:0]);
               lead_more  = 2'd3;
            end
            default: begin
               lead_value = u8d_pkg::CP_W'(text_byte);
               lead_more  = 2'd0;
            end
         endcase
         if (lead_more == 2'd0 || end_of_text) begin
            item.code_point = lead_value;
            item.last       = end_of_text;
            owed_code_points.insert(owed_code_points.size(), item);
            cont_left = 2'd0;
            cp_accum  = '0;
         end else begin
            cont_left = lead_more;
            cp_accum  = lead_value;
         end
      end else begin
         // Any byte inside a sequence counts as a continuation byte.
         cp_accum  = {cp_accum[u8d_pkg::CP_W-7:0], text_byte[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0 || end_of_text) begin
            item.code_point = cp_accum;
            item.last       = end_of_text;
            owed_code_points.insert(owed_code_points.size(), item);
            cont_left = 2'd0;
            cp_accum  = '0;
         end
      end
   endfunction

   // Compares one result leaving the block with the oldest code point owed: value, last flag and zero fill.
   function void check_code_point(logic [u8d_pkg::RSP_TDATA_W-1:0] data, logic last);
      code_point_item_type item;
      if (owed_code_points.size() == 0) begin
         $error("unexpected result: code_point %h last_of_text %b",
                data[u8d_pkg::CP_W-1:0], last);
         fail_count++;
         return;
      end
      item = owed_code_points.pop_front();
      if (data[u8d_pkg::CP_W-1:0] !== item.code_point) begin
         $error("code_point: expected %h actual %h", item.code_point,
                data[u8d_pkg::CP_W-1:0]);
         fail_count++;
      end
      if (last !== item.last) begin
         $error("last_of_text: expected %b actual %b", item.last, last);
         fail_count++;
      end
      if (data[u8d_pkg::RSP_TDATA_W-1:u8d_pkg::CP_W] !== '0) begin
         $error("zero_fill: expected %h actual %h",
                {(u8d_pkg::RSP_TDATA_W - u8d_pkg::CP_W){1'b0}},
                data[u8d_pkg::RSP_TDATA_W-1:u8d_pkg::CP_W]);
         fail_count++;
      end
   endfunction
endclass

module utf8_codepoint_decoder_test;

   localparam int unsigned RANDOM_BYTES = 1750;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 400;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [u8d_pkg::BYTE_W-1:0]      req_tdata  = '0;      // text_byte[7:0]
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [u8d_pkg::RSP_TDATA_W-1:0] rsp_tdata;            // code_point[20:0], zero fill
   logic                            rsp_tlast;

   code_point_tracker          tracker = new();
   int unsigned                idle_pct    = 27;
   int unsigned                bytes_sent  = 0;
   int unsigned                quiet_count = 0;
   bit                         hold_rsp    = 1'b0;
   logic [u8d_pkg::BYTE_W-1:0] text_q[$];

   utf8_codepoint_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one byte, after random idle cycles, and returns once the block has taken it.
   task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] text_byte,
                            input logic end_of_text);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= text_byte;
      req_tlast  <= end_of_text;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // The receiver stalls at random and, once asked, holds off for a long stretch.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp = 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Every accepted item on either side goes to the tracker; long silence ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_code_point(rsp_tdata, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
         end
         if (quiet_count >= STALL_LIMIT) begin
            $display("utf8_codepoint_decoder regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int unsigned n_chars;
      int unsigned char_len;
      int unsigned keep;
      logic [31:0] rnd;
      bit          hold_done;
      hold_done = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bytes: ASCII extremes, and a text that ends on a one-byte character.
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h41, 1'b1);
      // A byte without continuation bits inside a sequence is taken anyway.
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      // Largest two-byte value.
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // Text ends inside a three-byte sequence.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // Largest three-byte value, completed on the last byte of the text.
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      // Text ends on a four-byte lead.
      send_byte(8'hF0, 1'b1);
      // Largest four-byte value.
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // Bytes that are no valid lead pass through.
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF8, 1'b1);

      // Random texts: mostly well-formed characters, some noise and some truncation.
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         text_q.delete();
         n_chars = $urandom_range(1, 10);
         for (int c = 0; c < n_chars; c++) begin
            rnd = $urandom;
            if ($urandom_range(0, 99) < 80) begin
               char_len = $urandom_range(1, 4);
               case (char_len)
                  1: text_q.insert(text_q.size(), {1'b0, rnd[6:0]});
                  2: text_q.insert(text_q.size(), {3'b110, rnd[4:0]});
                  3: text_q.insert(text_q.size(), {4'b1110, rnd[3:0]});
                  default: text_q.insert(text_q.size(), {5'b11110, rnd[2:0]});
               endcase
               for (int k = 1; k < char_len; k++) begin
                  text_q.insert(text_q.size(), {2'b10, rnd[8 + 6*k +: 6]});
               end
            end else begin
               text_q.insert(text_q.size(), rnd[7:0]);
            end
         end
         if ($urandom_range(0, 99) < 15) begin
            keep = $urandom_range(1, text_q.size());
            while (text_q.size() > keep) void'(text_q.pop_back());
         end
         for (int i = 0; i < text_q.size(); i++) begin
            // A stretch without idling on either side.
            idle_pct = (bytes_sent >= 1000 && bytes_sent < 1400) ? 0 : 27;
            // Once, the receiver holds off while bytes keep coming.
            if (!hold_done && bytes_sent >= 600) begin
               hold_rsp  = 1'b1;
               hold_done = 1'b1;
            end
            send_byte(text_q[i], i == text_q.size() - 1);
         end
      end
      req_tvalid <= 1'b0;

      // Drain the owed code points, then allow the pipeline to settle.
      while (tracker.owed_code_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (tracker.fail_count == 0 && tracker.owed_code_points.size() == 0) begin
         $display("utf8_codepoint_decoder regression: pass");
      end else begin
         $display("utf8_codepoint_decoder regression: fail");
      end
      $finish;
   end

endmodule
